/* hw/rtl/dber_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dber_pkg
// Shared constants and types of the debounced button event reporter.
// ----------------------------------------------------------------------------
package dber_pkg;

    localparam int BUTTON_COUNT = 11;
    localparam int TIMER_WIDTH  = 16;

    localparam int IDX_W   = 4;
    localparam int DBT_W   = 16;
    localparam int THR_W   = (TIMER_WIDTH > DBT_W) ? TIMER_WIDTH : DBT_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEND_MASK      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAP_BUTTON     = 2'd2;

    localparam logic [DBT_W-1:0]        RST_DEBOUNCE = 16'd50;
    localparam logic [BUTTON_COUNT-1:0] RST_SEND     = BUTTON_COUNT'(99);
    localparam logic [IDX_W-1:0]        RST_LAP_BTN  = 4'd5;

    localparam logic [6:0] SEC_PER_MIN = 7'd60;
    localparam logic [5:0] SEC_MAX     = 6'd59;
    localparam logic [2:0] BYTES_MASK  = 3'd2;
    localparam logic [2:0] BYTES_LAP   = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    typedef struct packed {
        logic accept;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic expire;
        logic chg_nz;
        logic hit;
        logic out_free;
        logic rest_zero;
    } t_stat;

endpackage

/* hw/rtl/debounced_button_event_reporter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_button_event_reporter
// Shared-timer button debouncer that reports debounced changes and lap totals.
// ----------------------------------------------------------------------------
// Edge and non-expiring tick transactions complete in the cycle in which they are accepted.
// An expiring tick with changed pending buttons scans them one per cycle in the
// sequencer, holding while the result register is stalled, until none remain.
// Results appear in the cycle after their scan step; no transaction is taken during a scan.
// Reset is synchronous, active low: state clears, configuration registers take their defaults.
module debounced_button_event_reporter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dber_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dber_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_action,
    input  logic [dber_pkg::IDX_W-1:0]          i_button,
    input  logic [dber_pkg::BUTTON_COUNT-1:0]   i_levels,
    input  logic [7:0]                          i_lap_min_now,
    input  logic [5:0]                          i_lap_sec_now,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [dber_pkg::IDX_W-1:0]          o_msg_button,
    output logic                                o_is_press,
    output logic                                o_send,
    output logic [2:0]                          o_byte_count,
    output logic [dber_pkg::BUTTON_COUNT-1:0]   o_button_mask,
    output logic [7:0]                          o_lap_count,
    output logic [7:0]                          o_lap_min,
    output logic [5:0]                          o_lap_sec,
    output logic                                o_lap_clear,
    output logic [15:0]                         o_total_min,
    output logic [5:0]                          o_total_sec,
    output logic                                o_last
);

    dber_pkg::t_cmd  cmd;
    dber_pkg::t_stat stat;

    dber_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    dber_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_action      (i_action),
        .i_button      (i_button),
        .i_levels      (i_levels),
        .i_lap_min_now (i_lap_min_now),
        .i_lap_sec_now (i_lap_sec_now),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_msg_button  (o_msg_button),
        .o_is_press    (o_is_press),
        .o_send        (o_send),
        .o_byte_count  (o_byte_count),
        .o_button_mask (o_button_mask),
        .o_lap_count   (o_lap_count),
        .o_lap_min     (o_lap_min),
        .o_lap_sec     (o_lap_sec),
        .o_lap_clear   (o_lap_clear),
        .o_total_min   (o_total_min),
        .o_total_sec   (o_total_sec),
        .o_last        (o_last)
    );

endmodule

/* hw/rtl/dber_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dber_ctrl
// Sequencer: takes transactions while idle and walks the changed buttons.
// ----------------------------------------------------------------------------
module dber_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  dber_pkg::t_stat  i_stat,
    output dber_pkg::t_cmd   o_cmd
);

    dber_pkg::t_state r_state;
    dber_pkg::t_state n_state;

    always_comb begin
        o_ready      = (r_state == dber_pkg::ST_IDLE);
        o_cmd.accept = o_ready && i_valid;
        o_cmd.step   = 1'b0;
        n_state      = r_state;
        case (r_state)
            dber_pkg::ST_IDLE: begin
                if (o_cmd.accept && i_stat.expire && i_stat.chg_nz) begin
                    n_state = dber_pkg::ST_SCAN;
                end
            end
            dber_pkg::ST_SCAN: begin
                o_cmd.step = !i_stat.hit || i_stat.out_free;
                if (o_cmd.step && i_stat.rest_zero) begin
                    n_state = dber_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dber_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dber_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hw/rtl/dber_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dber_datapath
// Configuration, debounce timer, button state, lap totals and result register.
// ----------------------------------------------------------------------------
module dber_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dber_pkg::t_cmd                      i_cmd,
    output dber_pkg::t_stat                     o_stat,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dber_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dber_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_action,
    input  logic [dber_pkg::IDX_W-1:0]          i_button,
    input  logic [dber_pkg::BUTTON_COUNT-1:0]   i_levels,
    input  logic [7:0]                          i_lap_min_now,
    input  logic [5:0]                          i_lap_sec_now,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [dber_pkg::IDX_W-1:0]          o_msg_button,
    output logic                                o_is_press,
    output logic                                o_send,
    output logic [2:0]                          o_byte_count,
    output logic [dber_pkg::BUTTON_COUNT-1:0]   o_button_mask,
    output logic [7:0]                          o_lap_count,
    output logic [7:0]                          o_lap_min,
    output logic [5:0]                          o_lap_sec,
    output logic                                o_lap_clear,
    output logic [15:0]                         o_total_min,
    output logic [5:0]                          o_total_sec,
    output logic                                o_last
);

    localparam int BC = dber_pkg::BUTTON_COUNT;
    localparam int TW = dber_pkg::TIMER_WIDTH;
    localparam int HW = dber_pkg::THR_W;

    logic [dber_pkg::DBT_W-1:0]   r_debounce;
    logic [BC-1:0]                r_send_mask;
    logic [dber_pkg::IDX_W-1:0]   r_lap_btn;

    logic [BC-1:0]                r_pending;
    logic [BC-1:0]                r_pressed;
    logic [TW-1:0]                r_count;
    logic                         r_running;
    logic                         r_first_lap;
    logic [7:0]                   r_lap_cnt;
    logic [15:0]                  r_sum_min;
    logic [5:0]                   r_sum_sec;

    logic [BC-1:0]                r_chg;
    logic [dber_pkg::IDX_W-1:0]   r_idx;
    logic [7:0]                   r_lmin;
    logic [5:0]                   r_lsec;
    logic                         r_out_valid;

    logic [TW-1:0]                cnt_inc;
    logic [HW-1:0]                thr;
    logic                         expire;
    logic [BC-1:0]                chg_now;
    logic                         edge_ok;
    logic [BC-1:0]                btn_bit;
    logic [BC-1:0]                idx_bit;
    logic                         emit;
    logic                         is_press;
    logic                         lap_press;
    logic [6:0]                   sec_sum;
    logic                         carry;
    logic [5:0]                   n_sum_sec;
    logic [15:0]                  n_sum_min;
    logic [BC-1:0]                n_pressed;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        cnt_inc = r_count + TW'(1);
        if (HW'(r_debounce) > HW'({TW{1'b1}})) begin
            thr = HW'({TW{1'b1}});
        end else begin
            thr = HW'(r_debounce);
        end
        expire  = i_action && r_running && (HW'(cnt_inc) >= thr);
        chg_now = r_pending & (~i_levels ^ r_pressed);
        edge_ok = ({1'b0, i_button} < (dber_pkg::IDX_W + 1)'(BC));
        btn_bit = BC'(1) << i_button;
        idx_bit = BC'(1) << r_idx;
        emit      = i_cmd.step && r_chg[0];
        is_press  = ((r_pressed & idx_bit) == '0);
        lap_press = is_press && (r_idx == r_lap_btn);
        n_pressed = r_pressed ^ idx_bit;
        sec_sum   = {1'b0, r_sum_sec} + {1'b0, r_lsec};
        carry     = (sec_sum >= dber_pkg::SEC_PER_MIN);
        if (carry) begin
            n_sum_sec = 6'(sec_sum - dber_pkg::SEC_PER_MIN);
        end else begin
            n_sum_sec = sec_sum[5:0];
        end
        n_sum_min = r_sum_min + {8'd0, r_lmin} + {15'd0, carry};
    end

    assign o_stat.expire    = expire;
    assign o_stat.chg_nz    = (chg_now != '0);
    assign o_stat.hit       = r_chg[0];
    assign o_stat.out_free  = !r_out_valid || i_ready;
    assign o_stat.rest_zero = ((r_chg >> 1) == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce  <= dber_pkg::RST_DEBOUNCE;
            r_send_mask <= dber_pkg::RST_SEND;
            r_lap_btn   <= dber_pkg::RST_LAP_BTN;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dber_pkg::CFG_DEBOUNCE_TICKS: r_debounce  <= i_cfg_data;
                dber_pkg::CFG_SEND_MASK:      r_send_mask <= i_cfg_data[BC-1:0];
                dber_pkg::CFG_LAP_BUTTON:     r_lap_btn   <= i_cfg_data[dber_pkg::IDX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_pressed   <= '0;
            r_count     <= '0;
            r_running   <= 1'b0;
            r_first_lap <= 1'b0;
            r_lap_cnt   <= '0;
            r_sum_min   <= '0;
            r_sum_sec   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                if (!i_action) begin
                    if (edge_ok && ((r_pending & btn_bit) == '0)) begin
                        r_pending <= r_pending | btn_bit;
                        r_count   <= '0;
                        r_running <= 1'b1;
                    end
                end else if (r_running) begin
                    r_count <= cnt_inc;
                    if (expire) begin
                        r_running <= 1'b0;
                        r_pending <= '0;
                    end
                end
            end
            if (emit) begin
                r_pressed   <= n_pressed;
                r_out_valid <= 1'b1;
                if (lap_press) begin
                    r_first_lap <= 1'b1;
                    r_lap_cnt   <= r_lap_cnt + 8'd1;
                    r_sum_min   <= n_sum_min;
                    r_sum_sec   <= n_sum_sec;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && expire) begin
            r_chg <= chg_now;
            r_idx <= '0;
            r_lmin <= i_lap_min_now;
            r_lsec <= (i_lap_sec_now > dber_pkg::SEC_MAX) ? dber_pkg::SEC_MAX
                                                          : i_lap_sec_now;
        end else if (i_cmd.step) begin
            r_chg <= r_chg >> 1;
            r_idx <= r_idx + dber_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_msg_button  <= r_idx;
            o_is_press    <= is_press;
            o_button_mask <= n_pressed;
            o_last        <= ((r_chg >> 1) == '0);
            if (lap_press) begin
                o_send       <= ((r_send_mask & idx_bit) != '0) && r_first_lap;
                o_byte_count <= dber_pkg::BYTES_LAP;
                o_lap_count  <= r_lap_cnt;
                o_lap_min    <= r_lmin;
                o_lap_sec    <= r_lsec;
                o_lap_clear  <= 1'b1;
                o_total_min  <= n_sum_min;
                o_total_sec  <= n_sum_sec;
            end else begin
                o_send       <= ((r_send_mask & idx_bit) != '0);
                o_byte_count <= dber_pkg::BYTES_MASK;
                o_lap_count  <= '0;
                o_lap_min    <= '0;
                o_lap_sec    <= '0;
                o_lap_clear  <= 1'b0;
                o_total_min  <= r_sum_min;
                o_total_sec  <= r_sum_sec;
            end
        end
    end

    assign o_valid = r_out_valid;

    a_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum_sec <= dber_pkg::SEC_MAX)
        else $error("accumulated seconds out of range");

    a_expire_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && expire) |=> (r_pending == '0) && !r_running)
        else $error("expiry left pending buttons or a running timer");

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_out_valid) |-> i_ready)
        else $error("result overwritten before it was taken");

    a_lap_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && lap_press) |=> r_first_lap)
        else $error("lap press did not mark the first lap");

endmodule
